[hw/rtl/gpioei_pkg.sv]
package gpioei_pkg;

	localparam int PIN_COUNT = 32;
	localparam int WORD_W    = 32;

	// Only the low PIN_COUNT bits of any stored word exist.
	localparam logic [WORD_W-1:0] PIN_MASK = WORD_W'((64'd1 << PIN_COUNT) - 64'd1);

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 104;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	// Fixed word offsets.
	localparam logic [3:0] OFS_PEND    = 4'd0;
	localparam logic [3:0] OFS_EDGE    = 4'd1;
	localparam logic [3:0] OFS_RENA    = 4'd2;
	localparam logic [3:0] OFS_FENA    = 4'd3;
	// Base of the movable bank, without and with the register gap.
	localparam logic [3:0] OFS_BANK_LO = 4'd4;
	localparam logic [3:0] OFS_BANK_HI = 4'd8;
	localparam logic [3:0] BANK_SIZE   = 4'd6;

	typedef enum logic [2:0] {
		BANK_DATA  = 3'd0,
		BANK_DIR   = 3'd1,
		BANK_POL   = 3'd2,
		BANK_SET   = 3'd3,
		BANK_RESET = 3'd4,
		BANK_TOG   = 3'd5
	} bank_reg_t;

endpackage

[hw/rtl/gpio_controller_edge_irq.sv]
// GPIO controller with set/reset/toggle output registers and edge interrupts.
// Pipeline: an accepted request passes one input register, then one result register.
// Throughput: one request per cycle while m_axis_tready does not hold the output;
// the register file update is a single bitwise pass.
// Reset (arst_n low, asynchronous): all control and state words clear, the
// register gap returns to 0 and both pipeline stages empty.
module gpio_controller_edge_irq
	import gpioei_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_wr_data,     // register_gap
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// reg_word[3:0], write_data[35:4], pin_levels[67:36], zero fill above
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [1:0]            s_axis_tuser,    // cmd
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// read_data[31:0], pin_drive[63:32], pin_output_enable[95:64], irq[96], zero fill above
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic              register_gap_q;
	logic [WORD_W-1:0] output_word_q, direction_word_q, polarity_word_q;
	logic [WORD_W-1:0] rise_enable_q, fall_enable_q, pending_q, edge_kind_q, prev_levels_q;

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [3:0]        reg_word_s1;
	logic [WORD_W-1:0] write_data_s1, pin_levels_s1;

	logic              valid_s2;
	logic [WORD_W-1:0] read_data_s2, pin_drive_s2, pin_oe_s2;
	logic              irq_s2;

	logic advance;
	logic s_accept;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// Bank decode.
	logic [3:0]  bank_base, bank_rel;
	logic        bank_hit;
	bank_reg_t   bank_sel;

	assign bank_base = register_gap_q ? OFS_BANK_HI : OFS_BANK_LO;
	assign bank_rel  = reg_word_s1 - bank_base;
	assign bank_hit  = (reg_word_s1 >= bank_base) && (bank_rel < BANK_SIZE);
	assign bank_sel  = bank_reg_t'(bank_rel[2:0]);

	logic [WORD_W-1:0] out_n, dir_n, pol_n, rena_n, fena_n, pend_n, edge_n, prev_n;
	logic [WORD_W-1:0] rd, wv, lv, rise, fall, hit;

	always_comb begin
		out_n  = output_word_q;
		dir_n  = direction_word_q;
		pol_n  = polarity_word_q;
		rena_n = rise_enable_q;
		fena_n = fall_enable_q;
		pend_n = pending_q;
		edge_n = edge_kind_q;
		prev_n = prev_levels_q;
		rd     = '0;
		wv     = write_data_s1 & PIN_MASK;
		lv     = (pin_levels_s1 ^ polarity_word_q) & PIN_MASK;
		rise   = lv & ~prev_levels_q & rise_enable_q;
		fall   = ~lv & prev_levels_q & fall_enable_q;
		hit    = rise | fall;

		unique case (cmd_s1)
			CMD_READ: begin
				case (reg_word_s1)
					OFS_PEND: rd = pending_q;
					OFS_EDGE: rd = edge_kind_q;
					OFS_RENA: rd = rise_enable_q;
					OFS_FENA: rd = fall_enable_q;
					default: begin
						if (bank_hit) begin
							unique case (bank_sel)
								BANK_DATA: rd = (prev_levels_q & ~direction_word_q)
									| (output_word_q & direction_word_q);
								BANK_DIR: rd = direction_word_q;
								BANK_POL: rd = polarity_word_q;
								default:  rd = '0;
							endcase
						end
					end
				endcase
			end
			CMD_WRITE: begin
				case (reg_word_s1)
					OFS_PEND: pend_n = pending_q & ~wv;
					OFS_EDGE: ;
					OFS_RENA: rena_n = wv;
					OFS_FENA: fena_n = wv;
					default: begin
						if (bank_hit) begin
							unique case (bank_sel)
								BANK_DATA:  out_n = wv;
								BANK_DIR:   dir_n = wv;
								BANK_POL:   pol_n = wv;
								BANK_SET:   out_n = output_word_q | wv;
								BANK_RESET: out_n = output_word_q & ~wv;
								BANK_TOG:   out_n = output_word_q ^ wv;
								default: ;
							endcase
						end
					end
				endcase
			end
			CMD_TICK: begin
				pend_n = pending_q | hit;
				edge_n = (edge_kind_q & ~hit) | rise;
				prev_n = lv;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			register_gap_q <= 1'b0;
		end else if (cfg_wr_en) begin
			register_gap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_word_q    <= '0;
			direction_word_q <= '0;
			polarity_word_q  <= '0;
			rise_enable_q    <= '0;
			fall_enable_q    <= '0;
			pending_q        <= '0;
			edge_kind_q      <= '0;
			prev_levels_q    <= '0;
		end else if (advance) begin
			output_word_q    <= out_n;
			direction_word_q <= dir_n;
			polarity_word_q  <= pol_n;
			rise_enable_q    <= rena_n;
			fall_enable_q    <= fena_n;
			pending_q        <= pend_n;
			edge_kind_q      <= edge_n;
			prev_levels_q    <= prev_n;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1        <= cmd_t'(s_axis_tuser);
			reg_word_s1   <= s_axis_tdata[3:0];
			write_data_s1 <= s_axis_tdata[35:4];
			pin_levels_s1 <= s_axis_tdata[67:36];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_s2 <= rd;
			pin_drive_s2 <= out_n ^ pol_n;
			pin_oe_s2    <= dir_n;
			irq_s2       <= |pend_n;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, irq_s2, pin_oe_s2, pin_drive_s2, read_data_s2};

endmodule
